// ----- hdl/xed_pkg.sv -----
// Shared types and constants of the XML entity decoder.
package xed_pkg;

  localparam int HeldDepth = 8;
  localparam int HeldIdxW  = $clog2(HeldDepth);
  localparam int CntW      = $clog2(HeldDepth + 1);
  localparam int TailDepth = 3;
  localparam int TailCntW  = 2;
  localparam int ValueW    = 20;
  localparam int NameCount = 5;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChX    = 8'h78;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_AMP,
    PH_NAMED,
    PH_HASH,
    PH_DEC,
    PH_HEXX,
    PH_HEX
  } phase_e;

  typedef struct packed {
    logic [HeldDepth-1:0][7:0] held;
    logic [CntW-1:0]           hcnt;
    logic [TailDepth-1:0][7:0] tail;
    logic [TailCntW-1:0]       tcnt;
    logic                      last;
  } entry_t;

endpackage

// ----- hdl/xed_front.sv -----
// Entity matcher: tracks the open entity and builds at most one output job per input transfer.
module xed_front #(
  parameter int MAX_DEC_DIGITS = 6,
  parameter int MAX_HEX_DIGITS = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            stream_last_i,
  input  logic            q_full_i,
  output logic            push_o,
  output xed_pkg::entry_t push_entry_o
);

  localparam logic [xed_pkg::CntW-1:0] DecLimit = xed_pkg::CntW'(MAX_DEC_DIGITS + 2);
  localparam logic [xed_pkg::CntW-1:0] HexLimit = xed_pkg::CntW'(MAX_HEX_DIGITS + 3);

  function automatic logic [7:0] name_char_at(input logic [2:0] k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      3'd0: r = (p == 3'd0) ? 8'h6C : ((p == 3'd1) ? 8'h74 : 8'h00);
      3'd1: r = (p == 3'd0) ? 8'h67 : ((p == 3'd1) ? 8'h74 : 8'h00);
      3'd2: begin
        unique case (p)
          3'd0: r = 8'h61;
          3'd1: r = 8'h6D;
          3'd2: r = 8'h70;
          default: r = 8'h00;
        endcase
      end
      3'd3: begin
        unique case (p)
          3'd0: r = 8'h61;
          3'd1: r = 8'h70;
          3'd2: r = 8'h6F;
          3'd3: r = 8'h73;
          default: r = 8'h00;
        endcase
      end
      3'd4: begin
        unique case (p)
          3'd0: r = 8'h71;
          3'd1: r = 8'h75;
          3'd2: r = 8'h6F;
          3'd3: r = 8'h74;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] name_len(input logic [2:0] k);
    logic [2:0] r;
    unique case (k) inside
      3'd0, 3'd1: r = 3'd2;
      3'd2:       r = 3'd3;
      3'd3, 3'd4: r = 3'd4;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] name_out(input logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd0:    r = 8'h3C;
      3'd1:    r = 8'h3E;
      3'd2:    r = 8'h26;
      3'd3:    r = 8'h27;
      3'd4:    r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  xed_pkg::phase_e                    phase_q, phase_d;
  logic [xed_pkg::CntW-1:0]           cnt_q, cnt_d;
  logic [xed_pkg::ValueW-1:0]         val_q, val_d;
  logic [xed_pkg::NameCount-1:0]      mask_q, mask_d;
  logic [xed_pkg::HeldDepth-1:0][7:0] held_q, held_d;

  logic                               accept;
  logic [7:0]                         c;
  logic                               is_dec;
  logic [3:0]                         dec_val;
  logic                               is_hex;
  logic [3:0]                         hex_val;
  logic [2:0]                         pos;
  logic [xed_pkg::NameCount-1:0]      first_mask, next_mask, exact_mask;
  logic [7:0]                         exact_char;
  logic                               consumed, hold_c, finish, do_clear, use_held, idle_path;
  logic [xed_pkg::TailDepth-1:0][7:0] tail;
  logic [xed_pkg::TailCntW-1:0]       tcnt;
  logic [xed_pkg::ValueW-1:0]         v;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign c          = in_byte_i;
  assign pos        = 3'(cnt_q - xed_pkg::CntW'(1));

  always_comb begin
    is_dec  = (c >= 8'h30) && (c <= 8'h39);
    dec_val = c[3:0];
    is_hex  = 1'b1;
    hex_val = c[3:0];
    if (is_dec) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    exact_char = 8'h00;
    for (int k = 0; k < xed_pkg::NameCount; k++) begin
      first_mask[k] = (name_char_at(3'(k), 3'd0) == c);
      next_mask[k]  = mask_q[k] && (pos < name_len(3'(k))) && (name_char_at(3'(k), pos) == c);
      exact_mask[k] = mask_q[k] && (name_len(3'(k)) == pos);
    end
    for (int k = xed_pkg::NameCount - 1; k >= 0; k--) begin
      if (exact_mask[k]) begin
        exact_char = name_out(3'(k));
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    mask_d    = mask_q;
    held_d    = held_q;
    consumed  = 1'b0;
    hold_c    = 1'b0;
    finish    = 1'b0;
    do_clear  = 1'b0;
    use_held  = 1'b0;
    idle_path = 1'b0;
    tail      = '0;
    tcnt      = '0;
    v         = val_q;

    unique case (phase_q)
      xed_pkg::PH_AMP: begin
        if (c == xed_pkg::ChHash) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          phase_d  = xed_pkg::PH_HASH;
        end else if (|first_mask) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          phase_d  = xed_pkg::PH_NAMED;
          mask_d   = first_mask;
        end
      end
      xed_pkg::PH_NAMED: begin
        if (c == xed_pkg::ChSemi) begin
          if (|exact_mask) begin
            consumed = 1'b1;
            do_clear = 1'b1;
            tail[0]  = exact_char;
            tcnt     = 2'd1;
          end
        end else if (|next_mask) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          mask_d   = next_mask;
        end
      end
      xed_pkg::PH_HASH: begin
        if (c == xed_pkg::ChX) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          phase_d  = xed_pkg::PH_HEXX;
        end else if (is_dec) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          phase_d  = xed_pkg::PH_DEC;
          val_d    = xed_pkg::ValueW'(dec_val);
        end
      end
      xed_pkg::PH_DEC: begin
        if (c == xed_pkg::ChSemi) begin
          consumed = 1'b1;
          finish   = 1'b1;
        end else if (is_dec && (cnt_q < DecLimit)) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          val_d    = val_q * xed_pkg::ValueW'(10) + xed_pkg::ValueW'(dec_val);
        end
      end
      xed_pkg::PH_HEXX: begin
        if (is_hex) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          phase_d  = xed_pkg::PH_HEX;
          val_d    = xed_pkg::ValueW'(hex_val);
        end
      end
      xed_pkg::PH_HEX: begin
        if (c == xed_pkg::ChSemi) begin
          consumed = 1'b1;
          finish   = 1'b1;
        end else if (is_hex && (cnt_q < HexLimit)) begin
          consumed = 1'b1;
          hold_c   = 1'b1;
          val_d    = {val_q[xed_pkg::ValueW-5:0], hex_val};
        end
      end
      default: begin
        consumed = 1'b0;
      end
    endcase

    if (finish) begin
      do_clear = 1'b1;
      if (v == '0) begin
        tcnt = 2'd0;
      end else if (v < xed_pkg::ValueW'(20'h80)) begin
        tail[0] = v[7:0];
        tcnt    = 2'd1;
      end else if (v < xed_pkg::ValueW'(20'h800)) begin
        tail[0] = {3'b110, v[10:6]};
        tail[1] = {2'b10, v[5:0]};
        tcnt    = 2'd2;
      end else if (v <= xed_pkg::ValueW'(20'hFFFF)) begin
        tail[0] = {4'b1110, v[15:12]};
        tail[1] = {2'b10, v[11:6]};
        tail[2] = {2'b10, v[5:0]};
        tcnt    = 2'd3;
      end else begin
        use_held = 1'b1;
        tail[0]  = xed_pkg::ChSemi;
        tcnt     = 2'd1;
      end
    end

    if (hold_c) begin
      if (stream_last_i) begin
        use_held = 1'b1;
        tail[0]  = c;
        tcnt     = 2'd1;
        do_clear = 1'b1;
      end else begin
        held_d[cnt_q[xed_pkg::HeldIdxW-1:0]] = c;
        cnt_d = cnt_q + xed_pkg::CntW'(1);
      end
    end

    if (!consumed) begin
      idle_path = 1'b1;
      if (phase_q != xed_pkg::PH_IDLE) begin
        use_held = 1'b1;
      end
    end

    if (do_clear) begin
      phase_d = xed_pkg::PH_IDLE;
      cnt_d   = '0;
      val_d   = '0;
    end

    if (idle_path) begin
      if (c == xed_pkg::ChAmp) begin
        if (stream_last_i) begin
          tail[0] = c;
          tcnt    = 2'd1;
          phase_d = xed_pkg::PH_IDLE;
          cnt_d   = '0;
          val_d   = '0;
        end else begin
          held_d[0] = c;
          cnt_d     = xed_pkg::CntW'(1);
          phase_d   = xed_pkg::PH_AMP;
          val_d     = '0;
        end
      end else begin
        tail[0] = c;
        tcnt    = 2'd1;
        phase_d = xed_pkg::PH_IDLE;
        cnt_d   = '0;
        val_d   = '0;
      end
    end
  end

  always_comb begin
    push_entry_o.held = held_q;
    push_entry_o.hcnt = use_held ? cnt_q : '0;
    push_entry_o.tail = tail;
    push_entry_o.tcnt = tcnt;
    push_entry_o.last = stream_last_i;
    push_o = accept && (use_held || (tcnt != '0) || stream_last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xed_pkg::PH_IDLE;
      cnt_q   <= '0;
      val_q   <= '0;
      mask_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      val_q   <= val_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- hdl/xed_queue.sv -----
// Job queue between the entity matcher and the byte emitter.
module xed_queue #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xed_pkg::entry_t push_entry_i,
  output logic            full_o,
  output logic            valid_o,
  output xed_pkg::entry_t head_o,
  input  logic            pop_i
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  xed_pkg::entry_t    mem_q [Depth];
  logic [AddrW-1:0]   wr_q, rd_q;
  logic [CountW-1:0]  count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CountW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// ----- hdl/xed_back.sv -----
// Byte emitter: walks the head job byte by byte into the output register.
module xed_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  xed_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            run_last_o,
  output logic            stream_end_o
);

  localparam int IdxW = xed_pkg::CntW;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] total, off;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            has_q, has_d, run_q, run_d, end_q, end_d;
  logic            emit, fin;

  always_comb begin
    emit  = head_valid_i && (!out_valid_q || !out_stall_i);
    total = head_i.hcnt + IdxW'(head_i.tcnt);
    off   = idx_q - head_i.hcnt;
    fin   = (total == '0) || (idx_q == total - IdxW'(1));
    if (total == '0) begin
      byte_d = 8'h00;
      has_d  = 1'b0;
    end else if (idx_q < head_i.hcnt) begin
      byte_d = head_i.held[idx_q[xed_pkg::HeldIdxW-1:0]];
      has_d  = 1'b1;
    end else begin
      byte_d = head_i.tail[off[xed_pkg::TailCntW-1:0]];
      has_d  = 1'b1;
    end
    run_d = fin;
    end_d = fin && head_i.last;
    pop_o = emit && fin;
    idx_d = idx_q;
    if (emit) begin
      idx_d = fin ? '0 : idx_q + IdxW'(1);
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      run_q  <= run_d;
      end_q  <= end_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign has_byte_o   = has_q;
  assign run_last_o   = run_q;
  assign stream_end_o = end_q;

endmodule

// ----- hdl/xml_entity_decoder_core.sv -----
// Top level of the streaming XML entity decoder.
// Escaped text enters one byte per transfer and decoded bytes leave one per transfer. A byte
// that makes at most one output byte is a single-byte job, so plain text streams at one byte
// per clock while the output does not stall; a byte that releases several output bytes (a
// flushed partial entity, a multi-byte UTF-8 character, or the literal text of an oversized
// numeric entity, up to nine bytes) is sent one output byte per transfer by the emitter, which
// drains a small job queue. The input keeps flowing while that queue has room, so the input
// stalls only when the queue is full. Bytes held inside an open entity produce no output until
// it resolves, and the final byte of a stream always yields at least one output transfer, an
// empty one with has_byte_o low when nothing else is due.
module xml_entity_decoder_core #(
  parameter int MAX_DEC_DIGITS = 6,
  parameter int MAX_HEX_DIGITS = 5,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       run_last_o,
  output logic       stream_end_o
);

  logic            q_full, q_valid, push, pop;
  xed_pkg::entry_t push_entry, head;

  xed_front #(
    .MAX_DEC_DIGITS(MAX_DEC_DIGITS),
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .stream_last_i(stream_last_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  xed_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  xed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o)
  );

endmodule
